// ===== hdl/slit_scan_row_delay_defines.svh =====
// assertion macros for the slit-scan row delay
`ifndef SLIT_SCAN_ROW_DELAY_DEFINES_SVH
`define SLIT_SCAN_ROW_DELAY_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define SSRD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssrd check failed");

// next-cycle implication, checked out of reset
`define SSRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssrd check failed");

`else

`define SSRD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SSRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/ssrd_pkg.sv =====
`default_nettype none

package ssrd_pkg;

  // history geometry defaults
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // pixel payload
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;

  // configuration registers
  localparam int CFG_W      = 7;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

  localparam logic [APB_ADDR_W-1:0] REG_ACTIVE_WIDTH  = 3'd0;
  localparam logic [APB_ADDR_W-1:0] REG_ACTIVE_HEIGHT = 3'd4;

endpackage

`default_nettype wire

// ===== hdl/ssrd_if.sv =====
`default_nettype none

// incoming pixel channel
interface ssrd_pix_in_if;
  logic                       valid;
  logic                       ready;
  logic [ssrd_pkg::CHAN_W-1:0] red_in;
  logic [ssrd_pkg::CHAN_W-1:0] green_in;
  logic [ssrd_pkg::CHAN_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

// time-displaced pixel channel
interface ssrd_pix_out_if;
  logic                       valid;
  logic                       ready;
  logic [ssrd_pkg::CHAN_W-1:0] red_out;
  logic [ssrd_pkg::CHAN_W-1:0] green_out;
  logic [ssrd_pkg::CHAN_W-1:0] blue_out;
  logic                       line_end;
  logic                       frame_end;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output line_end, output frame_end, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input line_end, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/slit_scan_row_delay.sv =====
// Slit-scan row delay: RGB pixels enter in raster order, one item per clock
// sustained while the output accepts, and each leaves via the read stage and
// output register as the pixel at the same position from min(row, frames
// seen) frames back. The rate is set by the frame history memory, which takes
// one write (the new pixel) and one read (the delayed pixel) per item; row
// zero and the frames before the history fills are served straight from the
// incoming pixel or the oldest stored frame. The history is not cleared after
// reset, so there is no start-up pass. The user sets sizes through the APB
// port (width at 0x0, height at 0x4) only while the block is idle, which the
// block does not enforce; zero counts as one, values over the maximum clamp.

`default_nettype none

`include "slit_scan_row_delay_defines.svh"

module slit_scan_row_delay #(
  parameter int MAX_WIDTH  = ssrd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ssrd_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  ssrd_pix_in_if.sink                          in_pix,
  ssrd_pix_out_if.source                       out_pix,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ssrd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ssrd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ssrd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);

  localparam int CW   = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW   = RW + RW + CW;
  localparam int CMPW = ((CW > ssrd_pkg::CFG_W) ? CW : ssrd_pkg::CFG_W) + 1;
  localparam int RCMPW = ((RW > ssrd_pkg::CFG_W) ? RW : ssrd_pkg::CFG_W) + 1;
  localparam int PW   = ssrd_pkg::PIX_W;
  localparam int CH   = ssrd_pkg::CHAN_W;

  // configuration registers
  logic [ssrd_pkg::CFG_W-1:0] width_r, height_r;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ssrd_pkg::CFG_SIZE_RESET;
      height_r <= ssrd_pkg::CFG_SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr)
        ssrd_pkg::REG_ACTIVE_WIDTH:  width_r  <= pwdata[ssrd_pkg::CFG_W-1:0];
        ssrd_pkg::REG_ACTIVE_HEIGHT: height_r <= pwdata[ssrd_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr)
      ssrd_pkg::REG_ACTIVE_WIDTH:  prdata = ssrd_pkg::APB_DATA_W'(width_r);
      ssrd_pkg::REG_ACTIVE_HEIGHT: prdata = ssrd_pkg::APB_DATA_W'(height_r);
      default:                     prdata = '0;
    endcase
  end

  // clamped frame size
  logic [CMPW-1:0]  eff_w;
  logic [RCMPW-1:0] eff_h;

  always_comb begin
    if (width_r == '0) begin
      eff_w = CMPW'(1);
    end else if (CMPW'(width_r) > CMPW'(MAX_WIDTH)) begin
      eff_w = CMPW'(MAX_WIDTH);
    end else begin
      eff_w = CMPW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = RCMPW'(1);
    end else if (RCMPW'(height_r) > RCMPW'(MAX_HEIGHT)) begin
      eff_h = RCMPW'(MAX_HEIGHT);
    end else begin
      eff_h = RCMPW'(height_r);
    end
  end

  // position and history counters
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [RW-1:0] slot_r, slot_nxt;
  logic [RW-1:0] seen_r, seen_nxt;

  logic          in_ready;
  logic          accept;
  logic          line_end, frame_end;
  logic [RW-1:0] delay;
  logic [RW-1:0] src_slot;
  logic [PW-1:0] in_word;

  assign accept    = in_pix.valid && in_ready;
  assign in_word   = {in_pix.red_in, in_pix.green_in, in_pix.blue_in};
  assign line_end  = (CMPW'(col_r) + CMPW'(1)) >= eff_w;
  assign frame_end = line_end && ((RCMPW'(row_r) + RCMPW'(1)) >= eff_h);
  assign delay     = (row_r < seen_r) ? row_r : seen_r;

  // source slot, modulo the history depth
  always_comb begin
    if (slot_r >= delay) begin
      src_slot = slot_r - delay;
    end else begin
      src_slot = RW'((RW+1)'(slot_r) + (RW+1)'(MAX_HEIGHT) - (RW+1)'(delay));
    end
  end

  // raster advance
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    seen_nxt = seen_r;
    if (accept) begin
      if (!line_end) begin
        col_nxt = col_r + CW'(1);
      end else begin
        col_nxt = '0;
        if (!frame_end) begin
          row_nxt = row_r + RW'(1);
        end else begin
          row_nxt  = '0;
          slot_nxt = (slot_r == RW'(MAX_HEIGHT - 1)) ? '0 : slot_r + RW'(1);
          if (seen_r < RW'(MAX_HEIGHT - 1)) begin
            seen_nxt = seen_r + RW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
      seen_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
      seen_r <= seen_nxt;
    end
  end

  // frame history: write the new pixel, read the delayed one
  logic [PW-1:0] rd_word;

  ssrd_hist_ram #(
    .AW (AW),
    .DW (PW)
  ) u_hist (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr ({slot_r, row_r, col_r}),
    .wr_data (in_word),
    .rd_en   (accept),
    .rd_addr ({src_slot, row_r, col_r}),
    .rd_data (rd_word)
  );

  // read stage, aligned with the memory output
  logic          s1_v_r;
  logic          s1_byp_r;
  logic [PW-1:0] s1_pix_r;
  logic          s1_le_r, s1_fe_r;
  logic          s1_adv;
  logic [PW-1:0] s1_word;

  // output register
  logic          out_v_r;
  logic [PW-1:0] out_pix_r;
  logic          out_le_r, out_fe_r;

  assign s1_adv   = s1_v_r && (!out_v_r || out_pix.ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign s1_word  = s1_byp_r ? s1_pix_r : rd_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_pix.valid;
    end
  end

  // zero delay reads the pixel being written, so take it directly
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byp_r <= (delay == '0);
      s1_pix_r <= in_word;
      s1_le_r  <= line_end;
      s1_fe_r  <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_pix.ready) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pix_r <= s1_word;
      out_le_r  <= s1_le_r;
      out_fe_r  <= s1_fe_r;
    end
  end

  assign in_pix.ready      = in_ready;
  assign out_pix.valid     = out_v_r;
  assign out_pix.red_out   = out_pix_r[PW-1 -: CH];
  assign out_pix.green_out = out_pix_r[CH +: CH];
  assign out_pix.blue_out  = out_pix_r[CH-1:0];
  assign out_pix.line_end  = out_le_r;
  assign out_pix.frame_end = out_fe_r;

  // checks
  `SSRD_ASSERT_IMPL(a_full_blocks_input, clk, rst_n, s1_v_r && out_v_r && !out_pix.ready, !in_ready)
  `SSRD_ASSERT_IMPL(a_seen_saturates, clk, rst_n, 1'b1, seen_r <= RW'(MAX_HEIGHT - 1))
  `SSRD_ASSERT_NEXT(a_frame_wraps, clk, rst_n, accept && frame_end, (row_r == '0) && (col_r == '0))
  `SSRD_ASSERT_NEXT(a_row0_bypass, clk, rst_n, accept && (row_r == '0), s1_v_r && s1_byp_r)

endmodule

`default_nettype wire

// ===== hdl/ssrd_hist_ram.sv =====
`default_nettype none

module ssrd_hist_ram #(
  parameter int AW = 18,
  parameter int DW = 24
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== test/tb_slit_scan_row_delay.sv =====
`default_nettype none

module tb_slit_scan_row_delay;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET = 1250;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SLOTS       = ssrd_pkg::MAX_HEIGHT_DEF;

  // first frame after reset: channel extremes and alternating bit patterns
  localparam logic [ssrd_pkg::PIX_W-1:0] EXTREME_PIXELS [12] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hAA55AA, 24'h55AA55, 24'h800000,
    24'h010101, 24'h7F7F7F, 24'h123456, 24'hFEDCBA
  };

  typedef struct packed {
    logic [ssrd_pkg::CHAN_W-1:0] red;
    logic [ssrd_pkg::CHAN_W-1:0] green;
    logic [ssrd_pkg::CHAN_W-1:0] blue;
    logic                        line_end;
    logic                        frame_end;
  } shown_pixel_t;

  // frame history predictor and store of expected displaced pixels
  class row_delay_scoreboard;
    logic [ssrd_pkg::PIX_W-1:0] frame_store [int unsigned];
    int unsigned                col_pos;
    int unsigned                row_pos;
    int unsigned                cur_slot;
    int unsigned                frames_done;
    logic [ssrd_pkg::CFG_W-1:0] width_reg;
    logic [ssrd_pkg::CFG_W-1:0] height_reg;
    shown_pixel_t               displaced_q [$];
    int unsigned                errors;

    function new();
      width_reg   = ssrd_pkg::CFG_SIZE_RESET;
      height_reg  = ssrd_pkg::CFG_SIZE_RESET;
      col_pos     = 0;
      row_pos     = 0;
      cur_slot    = 0;
      frames_done = 0;
      errors      = 0;
    endfunction

    static function int unsigned clamp_size(logic [ssrd_pkg::CFG_W-1:0] v,
                                            int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    static function int unsigned store_index(int unsigned slot, int unsigned row,
                                             int unsigned col);
      return ((slot % SLOTS) * ssrd_pkg::MAX_HEIGHT_DEF
              + (row % ssrd_pkg::MAX_HEIGHT_DEF)) * ssrd_pkg::MAX_WIDTH_DEF
             + (col % ssrd_pkg::MAX_WIDTH_DEF);
    endfunction

    // slot holding the frame that row r is displaced from
    static function int unsigned source_slot(int unsigned slot, int unsigned row,
                                             int unsigned seen);
      int unsigned delay;
      delay = (row < seen) ? row : seen;
      return (slot + SLOTS - delay) % SLOTS;
    endfunction

    // raster position after one pixel, with the row and frame end flags
    static function void step_position(inout int unsigned c, inout int unsigned r,
                                       inout int unsigned s, inout int unsigned f,
                                       input int unsigned w, input int unsigned h,
                                       output bit le, output bit fe);
      le = (c + 1 >= w);
      fe = le && (r + 1 >= h);
      if (!le) begin
        c++;
      end else begin
        c = 0;
        if (!fe) begin
          r++;
        end else begin
          r = 0;
          s = (s + 1) % SLOTS;
          if (f < SLOTS - 1) f++;
        end
      end
    endfunction

    function void set_size(logic [ssrd_pkg::APB_ADDR_W-1:0] addr,
                           logic [ssrd_pkg::CFG_W-1:0] value);
      case (addr)
        ssrd_pkg::REG_ACTIVE_WIDTH:  width_reg  = value;
        ssrd_pkg::REG_ACTIVE_HEIGHT: height_reg = value;
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [ssrd_pkg::PIX_W-1:0] pix);
      int unsigned                src;
      bit                         le;
      bit                         fe;
      logic [ssrd_pkg::PIX_W-1:0] old_pix;
      shown_pixel_t               px;
      frame_store[store_index(cur_slot, row_pos, col_pos)] = pix;
      src = store_index(source_slot(cur_slot, row_pos, frames_done), row_pos, col_pos);
      old_pix = frame_store.exists(src) ? frame_store[src] : '0;
      step_position(col_pos, row_pos, cur_slot, frames_done,
                    clamp_size(width_reg, ssrd_pkg::MAX_WIDTH_DEF),
                    clamp_size(height_reg, ssrd_pkg::MAX_HEIGHT_DEF), le, fe);
      px.red       = old_pix[23:16];
      px.green     = old_pix[15:8];
      px.blue      = old_pix[7:0];
      px.line_end  = le;
      px.frame_end = fe;
      displaced_q.push_back(px);
    endfunction

    function void compare_field(string name, logic [ssrd_pkg::CHAN_W-1:0] want,
                                logic [ssrd_pkg::CHAN_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_pixel(shown_pixel_t got);
      shown_pixel_t want;
      if (displaced_q.size() == 0) begin
        errors++;
        $display("%0t ns: pixel out with nothing expected, got %0h %0h %0h le=%b fe=%b",
                 $time, got.red, got.green, got.blue, got.line_end, got.frame_end);
        return;
      end
      want = displaced_q.pop_front();
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("line_end", ssrd_pkg::CHAN_W'(want.line_end),
                    ssrd_pkg::CHAN_W'(got.line_end));
      compare_field("frame_end", ssrd_pkg::CHAN_W'(want.frame_end),
                    ssrd_pkg::CHAN_W'(got.frame_end));
    endfunction

    // true if n pixels at these sizes, and the read of the pixel after them,
    // only touch history entries written since reset
    function bit plan_is_safe(logic [ssrd_pkg::CFG_W-1:0] w_reg,
                              logic [ssrd_pkg::CFG_W-1:0] h_reg, int unsigned n);
      bit          touched [int unsigned];
      int unsigned c;
      int unsigned r;
      int unsigned s;
      int unsigned f;
      int unsigned src;
      bit          le;
      bit          fe;
      c = col_pos;
      r = row_pos;
      s = cur_slot;
      f = frames_done;
      for (int unsigned k = 0; k <= n; k++) begin
        touched[store_index(s, r, c)] = 1'b1;
        src = store_index(source_slot(s, r, f), r, c);
        if (!frame_store.exists(src) && !touched.exists(src)) return 1'b0;
        step_position(c, r, s, f, clamp_size(w_reg, ssrd_pkg::MAX_WIDTH_DEF),
                      clamp_size(h_reg, ssrd_pkg::MAX_HEIGHT_DEF), le, fe);
      end
      return 1'b1;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ssrd_pkg::APB_ADDR_W-1:0] paddr;
  logic [ssrd_pkg::APB_DATA_W-1:0] pwdata;
  logic [ssrd_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  ssrd_pix_in_if  in_ch ();
  ssrd_pix_out_if out_ch ();

  row_delay_scoreboard sb = new();

  bit          sink_gaps = 1'b1;
  int unsigned hold_request = 0;

  slit_scan_row_delay uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_ch),
    .out_pix (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // accepted items on both channels
  always @(posedge clk) begin : handshake_monitor
    shown_pixel_t got_px;
    if (rst_n === 1'b1) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        sb.note_pixel({in_ch.red_in, in_ch.green_in, in_ch.blue_in});
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got_px = {out_ch.red_out, out_ch.green_out, out_ch.blue_out,
                  out_ch.line_end, out_ch.frame_end};
        sb.check_pixel(got_px);
      end
    end
  end

  // result side: random stalls per item, plus one long hold when asked
  initial begin : result_sink
    int unsigned wait_n;
    forever begin
      if (hold_request != 0) begin
        wait_n = hold_request;
        hold_request = 0;
      end else begin
        wait_n = sink_gaps ? $urandom_range(0, 10) : 0;
      end
      if (wait_n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
    end
  end

  // apb write: setup phase, access phase, then an idle phase
  task automatic apb_write_size(input logic [ssrd_pkg::APB_ADDR_W-1:0] addr,
                                input logic [ssrd_pkg::CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= ssrd_pkg::APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    sb.set_size(addr, value);
  endtask

  task automatic send_pixels(input logic [ssrd_pkg::PIX_W-1:0] pix_q [$], input bit gaps);
    int unsigned gap;
    foreach (pix_q[k]) begin
      gap = gaps ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid    <= 1'b1;
      in_ch.red_in   <= pix_q[k][23:16];
      in_ch.green_in <= pix_q[k][15:8];
      in_ch.blue_in  <= pix_q[k][7:0];
      do @(posedge clk); while (in_ch.ready !== 1'b1);
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sb.displaced_q.size() != 0);
  endtask

  function automatic void random_pixels(output logic [ssrd_pkg::PIX_W-1:0] q [$],
                                        input int unsigned n);
    q = {};
    repeat (n) q.push_back(ssrd_pkg::PIX_W'($urandom()));
  endfunction

  // sizes: mostly small, with both extremes and out of range values
  function automatic logic [ssrd_pkg::CFG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'd127;
      4: return ssrd_pkg::CFG_W'($urandom_range(65, 127));
      5: return ssrd_pkg::CFG_W'($urandom_range(1, 64));
      default: return ssrd_pkg::CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin : stimulus
    logic [ssrd_pkg::PIX_W-1:0] pix_q [$];
    logic [ssrd_pkg::CFG_W-1:0] w_next;
    logic [ssrd_pkg::CFG_W-1:0] h_next;
    int unsigned                n_next;
    int unsigned                sent;
    bit                         found;
    bit                         held;
    bit                         hold_due;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.red_in   <= '0;
    in_ch.green_in <= '0;
    in_ch.blue_in  <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 4x3 first frame passes straight through
    apb_write_size(ssrd_pkg::REG_ACTIVE_WIDTH, 7'd4);
    apb_write_size(ssrd_pkg::REG_ACTIVE_HEIGHT, 7'd3);
    pix_q = {};
    foreach (EXTREME_PIXELS[k]) pix_q.push_back(EXTREME_PIXELS[k]);
    send_pixels(pix_q, 1'b0);
    wait_drained();

    // second frame, stopping two pixels into row one
    random_pixels(pix_q, 6);
    send_pixels(pix_q, 1'b1);
    wait_drained();

    // width narrowed mid-row: the column count is already past the end
    apb_write_size(ssrd_pkg::REG_ACTIVE_WIDTH, 7'd2);
    random_pixels(pix_q, 3);
    send_pixels(pix_q, 1'b1);
    wait_drained();

    // zero sizes count as one, so every pixel closes a frame
    apb_write_size(ssrd_pkg::REG_ACTIVE_WIDTH, 7'd0);
    apb_write_size(ssrd_pkg::REG_ACTIVE_HEIGHT, 7'd0);
    random_pixels(pix_q, 3);
    send_pixels(pix_q, 1'b1);
    wait_drained();
    sent = 24;
    held = 1'b0;

    // random phases, sizes chosen so no never-written history is read
    while (sent < ITEM_TARGET) begin
      hold_due = !held && (sent > ITEM_TARGET / 3);
      n_next = hold_due ? $urandom_range(40, 120) : $urandom_range(1, 120);
      found = 1'b0;
      if ($urandom_range(0, 3) != 0 && sb.plan_is_safe(sb.width_reg, sb.height_reg, n_next)) begin
        w_next = sb.width_reg;
        h_next = sb.height_reg;
        found = 1'b1;
      end
      for (int unsigned tries = 0; tries < 40 && !found; tries++) begin
        w_next = pick_size();
        h_next = pick_size();
        found = sb.plan_is_safe(w_next, h_next, n_next);
      end
      // one-pixel frames always read the pixel just written
      if (!found) begin
        w_next = ssrd_pkg::CFG_W'($urandom_range(0, 1));
        h_next = ssrd_pkg::CFG_W'($urandom_range(0, 1));
      end
      if (w_next != sb.width_reg) apb_write_size(ssrd_pkg::REG_ACTIVE_WIDTH, w_next);
      if (h_next != sb.height_reg) apb_write_size(ssrd_pkg::REG_ACTIVE_HEIGHT, h_next);

      random_pixels(pix_q, n_next);
      if (hold_due) begin
        // output stalled for a long stretch while input keeps coming
        sink_gaps = 1'b1;
        hold_request = HOLD_CYCLES;
        held = 1'b1;
        send_pixels(pix_q, 1'b0);
      end else begin
        sink_gaps = ($urandom_range(0, 3) != 0);
        send_pixels(pix_q, $urandom_range(0, 3) != 0);
      end
      wait_drained();
      sent += n_next;
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
